FILE: src/evacc_pkg.sv
package evacc_pkg;

   localparam int DIR_W = 2;
   localparam int SPEED_W = 16;
   localparam int STEP_W = 3;
   localparam int LIMIT_W = 15;
   localparam int CFG_VALUE_W = 16;
   localparam int POS_OUT_W = 16;
   localparam int ID_W = 8;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int ENTRY_W = 11;
   localparam int PROD_W = 13;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACCEL_ENABLE = 3'd0,
      CSR_VALUE_MIN    = 3'd1,
      CSR_VALUE_MAX    = 3'd2,
      CSR_STEP_LIMIT   = 3'd3,
      CSR_ENCODER_ID   = 3'd4
   } csr_index_type;

   localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
   localparam logic signed [DIR_W-1:0] DIR_CW   = 2'sb01;
   localparam logic signed [DIR_W-1:0] DIR_CCW  = 2'sb11;

   localparam logic signed [SPEED_W-1:0] PLAIN_SPEED     = 16'sd1500;
   localparam logic signed [SPEED_W-1:0] PLAIN_SPEED_NEG = -16'sd1500;
   localparam logic signed [SPEED_W-1:0] SPEED_SAT       = 16'sd32767;
   localparam logic signed [SPEED_W-1:0] SPEED_SAT_NEG   = -16'sd32767;
   localparam logic signed [SPEED_W-1:0] DECAY_LEVEL     = 16'sd32;
   localparam logic signed [SPEED_W-1:0] DECAY_LEVEL_NEG = -16'sd32;

   localparam logic [STEP_W-1:0] LAST_STEP = 3'd4;

   localparam logic [CFG_VALUE_W-1:0] VALUE_MIN_RESET  = 16'd0;
   localparam logic [CFG_VALUE_W-1:0] VALUE_MAX_RESET  = 16'd65535;
   localparam logic [LIMIT_W-1:0]     STEP_LIMIT_RESET = 15'd16383;

   typedef struct packed {
      logic                      move;
      logic signed [SPEED_W-1:0] speed;
      logic [STEP_W-1:0]         accel_step;
      logic signed [DIR_W-1:0]   last_dir;
   } upd_type;

   // increment table, 16 times 1, 5, 30, 60, 120
   function automatic logic [ENTRY_W-1:0] inc_entry(input logic [STEP_W-1:0] idx);
      logic [ENTRY_W-1:0] e;
      unique case (idx)
         3'd0: e = 11'd16;
         3'd1: e = 11'd80;
         3'd2: e = 11'd480;
         3'd3: e = 11'd960;
         default: e = 11'd1920;
      endcase
      return e;
   endfunction

   // table entry times its own index
   function automatic logic [PROD_W-1:0] inc_product(input logic [STEP_W-1:0] idx);
      logic [PROD_W-1:0] p;
      unique case (idx)
         3'd0: p = 13'd0;
         3'd1: p = 13'd80;
         3'd2: p = 13'd960;
         3'd3: p = 13'd2880;
         default: p = 13'd7680;
      endcase
      return p;
   endfunction

   function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [SPEED_W:0] v);
      logic signed [SPEED_W-1:0] r;
      if (v > $signed({SPEED_SAT[SPEED_W-1], SPEED_SAT})) begin
         r = SPEED_SAT;
      end else if (v < $signed({SPEED_SAT_NEG[SPEED_W-1], SPEED_SAT_NEG})) begin
         r = SPEED_SAT_NEG;
      end else begin
         r = v[SPEED_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/evacc_speed.sv
module evacc_speed (
   input  logic                                        accel_en,
   input  logic [evacc_pkg::DIR_W-1:0]                 turn_dir,
   input  logic signed [evacc_pkg::SPEED_W-1:0]        speed_cur,
   input  logic [evacc_pkg::STEP_W-1:0]                accel_step_cur,
   input  logic signed [evacc_pkg::DIR_W-1:0]          last_dir_cur,
   output evacc_pkg::upd_type                          upd
);

   logic signed [evacc_pkg::DIR_W-1:0]     dir;
   logic [evacc_pkg::STEP_W-1:0]           step_n;
   logic signed [evacc_pkg::SPEED_W:0]     speed_wide;
   logic signed [evacc_pkg::SPEED_W:0]     entry_wide;
   logic signed [evacc_pkg::SPEED_W:0]     prod_wide;
   logic signed [evacc_pkg::SPEED_W:0]     sum;

   // unused code 2 counts as counterclockwise
   always_comb begin
      unique case (turn_dir)
         2'b00:   dir = evacc_pkg::DIR_NONE;
         2'b01:   dir = evacc_pkg::DIR_CW;
         default: dir = evacc_pkg::DIR_CCW;
      endcase
   end

   always_comb begin
      speed_wide = $signed({speed_cur[evacc_pkg::SPEED_W-1], speed_cur});
      entry_wide = $signed({6'b0, evacc_pkg::inc_entry(accel_step_cur)});
      step_n = '0;
      if (last_dir_cur == dir) begin
         step_n = (accel_step_cur >= evacc_pkg::LAST_STEP) ? '0 : accel_step_cur + 3'd1;
      end
      prod_wide = $signed({4'b0, evacc_pkg::inc_product(step_n)});
      sum = speed_wide;

      upd.move       = 1'b0;
      upd.speed      = speed_cur;
      upd.accel_step = accel_step_cur;
      upd.last_dir   = last_dir_cur;

      if (!accel_en) begin
         if (dir != evacc_pkg::DIR_NONE) begin
            upd.move  = 1'b1;
            upd.speed = (dir == evacc_pkg::DIR_CW) ? evacc_pkg::PLAIN_SPEED
                                                   : evacc_pkg::PLAIN_SPEED_NEG;
         end
      end else if (dir == evacc_pkg::DIR_NONE) begin
         // idle tick: pull speed back toward zero
         if (speed_cur > evacc_pkg::DECAY_LEVEL) begin
            sum = speed_wide - entry_wide;
         end else if (speed_cur < evacc_pkg::DECAY_LEVEL_NEG) begin
            sum = speed_wide + entry_wide;
         end
         upd.speed = evacc_pkg::sat_speed(sum);
      end else begin
         sum = (dir == evacc_pkg::DIR_CW) ? speed_wide + prod_wide : speed_wide - prod_wide;
         upd.move       = 1'b1;
         upd.accel_step = step_n;
         upd.last_dir   = dir;
         upd.speed      = evacc_pkg::sat_speed(sum);
      end
   end

endmodule

FILE: src/evacc_position.sv
module evacc_position #(
   parameter int VALUE_BITS = 16
) (
   input  logic                                     move,
   input  logic signed [evacc_pkg::SPEED_W-1:0]     speed,
   input  logic [evacc_pkg::LIMIT_W-1:0]            step_limit,
   input  logic [evacc_pkg::CFG_VALUE_W-1:0]        value_min,
   input  logic [evacc_pkg::CFG_VALUE_W-1:0]        value_max,
   input  logic [VALUE_BITS-1:0]                    pos_cur,
   output logic [VALUE_BITS-1:0]                    pos_next,
   output logic [evacc_pkg::POS_OUT_W-1:0]          pos_out,
   output logic                                     changed
);

   localparam int CALC_W = ((VALUE_BITS > evacc_pkg::CFG_VALUE_W) ?
                            VALUE_BITS : evacc_pkg::CFG_VALUE_W) + 2;

   logic signed [evacc_pkg::SPEED_W:0] lim_pos;
   logic signed [evacc_pkg::SPEED_W:0] lim_neg;
   logic signed [evacc_pkg::SPEED_W:0] spd;
   logic signed [evacc_pkg::SPEED_W:0] stepv;
   logic signed [CALC_W-1:0]           nv_sum;
   logic signed [CALC_W-1:0]           nv_rng;
   logic signed [CALC_W-1:0]           nv_top;
   logic signed [CALC_W-1:0]           vmin;
   logic signed [CALC_W-1:0]           vmax;
   logic signed [CALC_W-1:0]           top;
   logic [CALC_W-1:0]                  pos_wide;

   always_comb begin
      lim_pos = $signed({2'b00, step_limit});
      lim_neg = -lim_pos;
      spd     = $signed({speed[evacc_pkg::SPEED_W-1], speed});
      if (spd > lim_pos) begin
         stepv = lim_pos;
      end else if (spd < lim_neg) begin
         stepv = lim_neg;
      end else begin
         stepv = spd;
      end

      vmin = $signed({{(CALC_W-evacc_pkg::CFG_VALUE_W){1'b0}}, value_min});
      vmax = $signed({{(CALC_W-evacc_pkg::CFG_VALUE_W){1'b0}}, value_max});
      top  = $signed({{(CALC_W-VALUE_BITS){1'b0}}, {VALUE_BITS{1'b1}}});

      nv_sum = $signed({{(CALC_W-VALUE_BITS){1'b0}}, pos_cur}) + CALC_W'(stepv);

      // with an inverted range a sum below the low bound takes it, any other sum the high bound
      if (nv_sum < vmin) begin
         nv_rng = vmin;
      end else if (nv_sum > vmax) begin
         nv_rng = vmax;
      end else begin
         nv_rng = nv_sum;
      end

      if (nv_rng > top) begin
         nv_top = top;
      end else if (nv_rng < $signed(CALC_W'(0))) begin
         nv_top = '0;
      end else begin
         nv_top = nv_rng;
      end

      pos_next = move ? nv_top[VALUE_BITS-1:0] : pos_cur;
      changed  = (pos_next != pos_cur);
      pos_wide = {{(CALC_W-VALUE_BITS){1'b0}}, pos_next};
      pos_out  = pos_wide[evacc_pkg::POS_OUT_W-1:0];
   end

endmodule

FILE: src/encoder_velocity_accelerator.sv
// Rotary encoder velocity accelerator.
// Input channel (req_): one detent word per transfer, req_turn_dir = +1 clockwise,
// -1 counterclockwise, 0 idle tick. Result channel (rsp_): one word per input word
// with rsp_changed, the new rsp_position and rsp_which_encoder.
// A word is taken when valid is high and stall is low on that channel.
// Control port (csr_): csr_we writes csr_wdata to the register at csr_index
// (0 accel enable, 1 value min, 2 value max, 3 step limit, 4 encoder id);
// write only while no word is in flight.
// A taken word lands in the input register, then moves on to the result register when
// that register is free or draining, and shows on rsp_ from there. Throughput: one word
// per cycle while rsp_stall is low; speed, table index, last direction and
// position update in the single stage between the two registers.
// When rsp_stall holds, the result register keeps its word; the input register
// still fills, and req_stall rises only when both registers are full.
// Synchronous reset clears both channels, the state (speed, index, direction,
// position = 0) and loads the register defaults (min 0, max 65535, limit 16383).
module encoder_velocity_accelerator #(
   parameter int VALUE_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [evacc_pkg::DIR_W-1:0]        req_turn_dir,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic                                      rsp_changed,
   output logic [evacc_pkg::POS_OUT_W-1:0]           rsp_position,
   output logic [evacc_pkg::ID_W-1:0]                rsp_which_encoder,
   input  logic                                      csr_we,
   input  logic [evacc_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [evacc_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   logic                                  accel_en_ff;
   logic [evacc_pkg::CFG_VALUE_W-1:0]     value_min_ff;
   logic [evacc_pkg::CFG_VALUE_W-1:0]     value_max_ff;
   logic [evacc_pkg::LIMIT_W-1:0]         step_limit_ff;
   logic [evacc_pkg::ID_W-1:0]            encoder_id_ff;

   logic                                  in_valid_ff;
   logic                                  in_valid_in;
   logic [evacc_pkg::DIR_W-1:0]           in_dir_ff;

   logic signed [evacc_pkg::SPEED_W-1:0]  speed_ff;
   logic [evacc_pkg::STEP_W-1:0]          accel_step_ff;
   logic signed [evacc_pkg::DIR_W-1:0]    last_dir_ff;
   logic [VALUE_BITS-1:0]                 position_ff;

   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic                                  rsp_changed_ff;
   logic [evacc_pkg::POS_OUT_W-1:0]       rsp_position_ff;
   logic [evacc_pkg::ID_W-1:0]            rsp_which_ff;

   logic                                  advance;
   logic                                  accept;
   evacc_pkg::upd_type                    upd;
   logic [VALUE_BITS-1:0]                 pos_next;
   logic [evacc_pkg::POS_OUT_W-1:0]       pos_out;
   logic                                  pos_changed;

   evacc_speed u_speed (
      .accel_en       (accel_en_ff),
      .turn_dir       (in_dir_ff),
      .speed_cur      (speed_ff),
      .accel_step_cur (accel_step_ff),
      .last_dir_cur   (last_dir_ff),
      .upd            (upd)
   );

   evacc_position #(
      .VALUE_BITS (VALUE_BITS)
   ) u_position (
      .move       (upd.move),
      .speed      (upd.speed),
      .step_limit (step_limit_ff),
      .value_min  (value_min_ff),
      .value_max  (value_max_ff),
      .pos_cur    (position_ff),
      .pos_next   (pos_next),
      .pos_out    (pos_out),
      .changed    (pos_changed)
   );

   // the input word moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_en_ff   <= 1'b0;
         value_min_ff  <= evacc_pkg::VALUE_MIN_RESET;
         value_max_ff  <= evacc_pkg::VALUE_MAX_RESET;
         step_limit_ff <= evacc_pkg::STEP_LIMIT_RESET;
         encoder_id_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            evacc_pkg::CSR_ACCEL_ENABLE: accel_en_ff   <= csr_wdata[0];
            evacc_pkg::CSR_VALUE_MIN:    value_min_ff  <= csr_wdata[evacc_pkg::CFG_VALUE_W-1:0];
            evacc_pkg::CSR_VALUE_MAX:    value_max_ff  <= csr_wdata[evacc_pkg::CFG_VALUE_W-1:0];
            evacc_pkg::CSR_STEP_LIMIT:   step_limit_ff <= csr_wdata[evacc_pkg::LIMIT_W-1:0];
            evacc_pkg::CSR_ENCODER_ID:   encoder_id_ff <= csr_wdata[evacc_pkg::ID_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         speed_ff      <= '0;
         accel_step_ff <= '0;
         last_dir_ff   <= evacc_pkg::DIR_NONE;
         position_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            speed_ff      <= upd.speed;
            accel_step_ff <= upd.accel_step;
            last_dir_ff   <= upd.last_dir;
            position_ff   <= pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_dir_ff <= req_turn_dir;
      end
      if (advance) begin
         rsp_changed_ff  <= pos_changed;
         rsp_position_ff <= pos_out;
         rsp_which_ff    <= encoder_id_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_changed       = rsp_changed_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_which_encoder = rsp_which_ff;

   a_step_in_table: assert property (@(posedge clock) disable iff (reset)
      accel_step_ff <= evacc_pkg::LAST_STEP)
      else $error("acceleration index beyond table");

   a_speed_sat: assert property (@(posedge clock) disable iff (reset)
      speed_ff >= evacc_pkg::SPEED_SAT_NEG)
      else $error("speed below saturation bound");

   a_plain_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && !accel_en_ff && in_dir_ff == evacc_pkg::DIR_NONE)
      |=> (rsp_valid && !rsp_changed))
      else $error("idle tick in plain mode moved the position");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && in_valid_ff) |-> req_stall)
      else $error("input taken while both registers full");

endmodule

FILE: tb/encoder_velocity_accelerator_test.sv
`timescale 1ns / 100ps

module encoder_velocity_accelerator_test;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 80;
   localparam int VEL_UNIT = 16;
   localparam int PHASE_ITEMS = 155;
   localparam int RANDOM_PHASES = 12;
   // unused direction pattern, behaves as counterclockwise
   localparam logic [evacc_pkg::DIR_W-1:0] DIR_CCW_ALT = 2'b10;

   typedef struct packed {
      logic                            changed;
      logic [evacc_pkg::POS_OUT_W-1:0] position;
      logic [evacc_pkg::ID_W-1:0]      which_encoder;
   } position_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [evacc_pkg::DIR_W-1:0] req_turn_dir = evacc_pkg::DIR_NONE;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_changed;
   logic [evacc_pkg::POS_OUT_W-1:0] rsp_position;
   logic [evacc_pkg::ID_W-1:0] rsp_which_encoder;
   logic csr_we = 1'b0;
   logic [evacc_pkg::CSR_INDEX_W-1:0] csr_index = evacc_pkg::CSR_ACCEL_ENABLE;
   logic [evacc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic [evacc_pkg::DIR_W-1:0] pending_turns[$];
   position_report_type position_reports[$];
   int fail_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 28;
   int recv_idle_pct = 28;
   bit hold_armed = 1'b0;
   int hold_left = 0;

   // tracked encoder state and register copies
   int trk_speed;
   int trk_step;
   int trk_dir;
   logic [evacc_pkg::POS_OUT_W-1:0] trk_position;
   bit cfg_accel;
   int cfg_min;
   int cfg_max;
   int cfg_limit;
   logic [evacc_pkg::ID_W-1:0] cfg_id;

   encoder_velocity_accelerator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_turn_dir(req_turn_dir),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_changed(rsp_changed),
      .rsp_position(rsp_position),
      .rsp_which_encoder(rsp_which_encoder),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int detent_increment(input int idx);
      int inc;
      case (idx)
         0: inc = VEL_UNIT * 1;
         1: inc = VEL_UNIT * 5;
         2: inc = VEL_UNIT * 30;
         3: inc = VEL_UNIT * 60;
         default: inc = VEL_UNIT * 120;
      endcase
      return inc;
   endfunction

   function automatic int clamp_speed(input int v);
      int r;
      r = v;
      if (v > 32767) r = 32767;
      else if (v < -32767) r = -32767;
      return r;
   endfunction

   task automatic track_detent(input logic [evacc_pkg::DIR_W-1:0] code);
      int dir;
      int stepv;
      int nv;
      bit moved;
      logic [evacc_pkg::POS_OUT_W-1:0] prior;
      position_report_type w;
      dir = (code == evacc_pkg::DIR_NONE) ? 0 : (code == evacc_pkg::DIR_CW) ? 1 : -1;
      prior = trk_position;
      moved = 1'b0;
      if (!cfg_accel) begin
         if (dir != 0) begin
            trk_speed = 1500 * dir;
            moved = 1'b1;
         end
      end else if (dir == 0) begin
         // decay toward zero outside the dead band
         if (trk_speed > 2 * VEL_UNIT) begin
            trk_speed = clamp_speed(trk_speed - detent_increment(trk_step));
         end else if (trk_speed < -2 * VEL_UNIT) begin
            trk_speed = clamp_speed(trk_speed + detent_increment(trk_step));
         end
      end else begin
         if (trk_dir == dir) trk_step = (trk_step >= 4) ? 0 : trk_step + 1;
         else trk_step = 0;
         trk_dir = dir;
         trk_speed = clamp_speed(trk_speed + detent_increment(trk_step) * trk_step * dir);
         moved = 1'b1;
      end
      if (moved) begin
         stepv = trk_speed;
         if (stepv > cfg_limit) stepv = cfg_limit;
         if (stepv < -cfg_limit) stepv = -cfg_limit;
         nv = int'(trk_position) + stepv;
         // inverted range: a value below the lower bound takes it, any other the upper bound
         if (nv < cfg_min) nv = cfg_min;
         else if (nv > cfg_max) nv = cfg_max;
         if (nv > 65535) nv = 65535;
         if (nv < 0) nv = 0;
         trk_position = nv[evacc_pkg::POS_OUT_W-1:0];
      end
      w.changed = (trk_position != prior);
      w.position = trk_position;
      w.which_encoder = cfg_id;
      position_reports.push_back(w);
   endtask

   // mirror register writes and predict every accepted word
   always @(posedge clock) begin
      if (reset) begin
         trk_speed = 0;
         trk_step = 0;
         trk_dir = 0;
         trk_position = '0;
         cfg_accel = 1'b0;
         cfg_min = int'(evacc_pkg::VALUE_MIN_RESET);
         cfg_max = int'(evacc_pkg::VALUE_MAX_RESET);
         cfg_limit = int'(evacc_pkg::STEP_LIMIT_RESET);
         cfg_id = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               evacc_pkg::CSR_ACCEL_ENABLE: cfg_accel = csr_wdata[0];
               evacc_pkg::CSR_VALUE_MIN:    cfg_min = int'(csr_wdata);
               evacc_pkg::CSR_VALUE_MAX:    cfg_max = int'(csr_wdata);
               evacc_pkg::CSR_STEP_LIMIT:   cfg_limit = int'(csr_wdata[evacc_pkg::LIMIT_W-1:0]);
               evacc_pkg::CSR_ENCODER_ID:   cfg_id = csr_wdata[evacc_pkg::ID_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) track_detent(req_turn_dir);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_turns.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_turn_dir <= pending_turns.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_armed) begin
         hold_armed = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (position_reports.size() == 0) begin
            $display("%0t: unexpected word changed=%0d position=%0d encoder=%0d", $time,
                     rsp_changed, rsp_position, rsp_which_encoder);
            fail_count++;
         end else begin
            position_report_type want;
            position_report_type got;
            want = position_reports.pop_front();
            got = '{rsp_changed, rsp_position, rsp_which_encoder};
            if (got !== want) begin
               $display("%0t: expected changed=%0d position=%0d encoder=%0d,", $time,
                        want.changed, want.position, want.which_encoder,
                        " got changed=%0d position=%0d encoder=%0d",
                        got.changed, got.position, got.which_encoder);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** encoder_velocity_accelerator: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(input evacc_pkg::csr_index_type idx,
                            input logic [evacc_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_registers(input bit accel, input int vmin, input int vmax,
                                input int limit, input int id);
      write_reg(evacc_pkg::CSR_ACCEL_ENABLE, evacc_pkg::CSR_DATA_W'(accel));
      write_reg(evacc_pkg::CSR_VALUE_MIN, evacc_pkg::CSR_DATA_W'(vmin));
      write_reg(evacc_pkg::CSR_VALUE_MAX, evacc_pkg::CSR_DATA_W'(vmax));
      write_reg(evacc_pkg::CSR_STEP_LIMIT, evacc_pkg::CSR_DATA_W'(limit));
      write_reg(evacc_pkg::CSR_ENCODER_ID, evacc_pkg::CSR_DATA_W'(id));
      @(negedge clock);
   endtask

   task automatic wait_drained;
      while (pending_turns.size() != 0 || req_valid || position_reports.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // mostly same-direction runs so the increment table and saturation get exercised
   task automatic queue_turns(input int count);
      int left;
      int kind;
      int len;
      bit cw;
      left = count;
      while (left > 0) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            cw = 1'($urandom_range(0, 1));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
            for (int k = 0; k < len && left > 0; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  pending_turns.push_back(evacc_pkg::DIR_NONE);
                  left--;
               end
               if (cw) pending_turns.push_back(evacc_pkg::DIR_CW);
               else if ($urandom_range(0, 7) == 0) pending_turns.push_back(DIR_CCW_ALT);
               else pending_turns.push_back(evacc_pkg::DIR_CCW);
               left--;
            end
         end else if (kind < 85) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len && left > 0; k++) begin
               pending_turns.push_back(evacc_pkg::DIR_NONE);
               left--;
            end
         end else begin
            pending_turns.push_back(evacc_pkg::DIR_W'($urandom_range(0, 3)));
            left--;
         end
      end
   endtask

   initial begin
      int vmin;
      int vmax;
      int limit;
      int swap;
      bit accel;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // plain mode from reset: idle tick, move below the floor, unused pattern, steps up
      pending_turns = '{evacc_pkg::DIR_NONE, evacc_pkg::DIR_CCW, DIR_CCW_ALT,
                        evacc_pkg::DIR_CW, evacc_pkg::DIR_CW, evacc_pkg::DIR_CW,
                        evacc_pkg::DIR_NONE, DIR_CCW_ALT};
      wait_drained();

      // accelerated: table wrap, decay on idle ticks, reversal, unused pattern
      set_registers(1'b1, 0, 65535, 32767, 255);
      pending_turns = '{evacc_pkg::DIR_CW, evacc_pkg::DIR_CW, evacc_pkg::DIR_CW,
                        evacc_pkg::DIR_CW, evacc_pkg::DIR_CW, evacc_pkg::DIR_CW,
                        evacc_pkg::DIR_NONE, evacc_pkg::DIR_NONE, evacc_pkg::DIR_NONE,
                        evacc_pkg::DIR_CCW, evacc_pkg::DIR_CCW, DIR_CCW_ALT,
                        evacc_pkg::DIR_NONE, evacc_pkg::DIR_CW};
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         send_idle_pct = 28;
         recv_idle_pct = 28;
         case (p)
            0: begin
               set_registers(1'b1, 0, 65535, 32767, 0);
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            1: set_registers(1'b1, 1000, 5000, 0, 17);
            2: set_registers(1'b0, 50000, 20000, 16383, 128);
            3: set_registers(1'b1, 65535, 0, 500, 1);
            4: set_registers(1'b0, 0, 65535, 1, 254);
            default: begin
               accel = ($urandom_range(0, 3) != 0);
               vmin = $urandom_range(0, 65535);
               vmax = $urandom_range(0, 65535);
               if (vmin > vmax && $urandom_range(0, 4) != 0) begin
                  swap = vmin;
                  vmin = vmax;
                  vmax = swap;
               end
               case ($urandom_range(0, 3))
                  0: limit = $urandom_range(0, 64);
                  1: limit = $urandom_range(0, 3000);
                  2: limit = 32767;
                  default: limit = $urandom_range(0, 32767);
               endcase
               set_registers(accel, vmin, vmax, limit, $urandom_range(0, 255));
            end
         endcase
         queue_turns(PHASE_ITEMS);
         // long receiver hold while the sender keeps offering words
         if (p == 1 || p == 4 || p == 9) begin
            send_idle_pct = 0;
            hold_armed = 1'b1;
         end
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (position_reports.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, position_reports.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("** encoder_velocity_accelerator: PASSED **");
      end else begin
         $display("** encoder_velocity_accelerator: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
src/evacc_pkg.sv
src/evacc_speed.sv
src/evacc_position.sv
src/encoder_velocity_accelerator.sv
tb/encoder_velocity_accelerator_test.sv
